// ===== design/bdq_pkg.sv =====
package bdq_pkg;

    // Default ring size.
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths of the request and response words.
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request word is taken this cycle
        logic scan;     // a search step runs this cycle
    } bdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_scan;   // the offered request is a find over a non-empty ring
        logic scan_done;    // the running search ends this cycle
    } bdq_sts_t;

endpackage

// ===== design/bdq_req_if.sv =====
interface bdq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bdq_pkg::MODE_W-1:0]    mode;
    logic signed [bdq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== design/bdq_rsp_if.sv =====
interface bdq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bdq_pkg::STATUS_W-1:0]     status;
    logic [bdq_pkg::POS_W-1:0]        found_position;
    logic [bdq_pkg::COUNT_W-1:0]      entry_count;

    modport source (output valid, output status, output found_position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_position,
                    input entry_count, output ready);
endinterface

// ===== design/bdq_ctrl.sv =====
module bdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bdq_pkg::bdq_sts_t sts,
    output bdq_pkg::bdq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    // A new word is taken only when idle and the result slot is free or emptying.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.accept = accept;
    assign cmd.scan   = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.needs_scan)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/bdq_datapath.sv =====
module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bdq_pkg::bdq_cmd_t                    cmd,
    output bdq_pkg::bdq_sts_t                    sts,
    input  logic        [bdq_pkg::MODE_W-1:0]    mode,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   value,
    output logic        [bdq_pkg::STATUS_W-1:0]  status,
    output logic        [bdq_pkg::POS_W-1:0]     found_position,
    output logic        [bdq_pkg::COUNT_W-1:0]   entry_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [bdq_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [PW-1:0] scan_ptr_reg;
    logic [PW-1:0] scan_ptr_next;
    logic [CW-1:0] issue_idx_reg;
    logic [CW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic [bdq_pkg::VALUE_W-1:0] key_reg;
    logic [bdq_pkg::VALUE_W-1:0] rd_data_reg;

    logic [bdq_pkg::STATUS_W-1:0] status_reg;
    logic [bdq_pkg::STATUS_W-1:0] status_next;
    logic [bdq_pkg::POS_W-1:0]    pos_reg;
    logic [bdq_pkg::POS_W-1:0]    pos_next;
    logic [bdq_pkg::COUNT_W-1:0]  cnt_out_reg;
    logic [bdq_pkg::COUNT_W-1:0]  cnt_out_next;

    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic          is_full;
    logic          is_empty;
    logic          match;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] back_wrap;
    logic [PW-1:0] back_addr;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] front_inc;
    logic [CW+bdq_pkg::POS_W-1:0]   pos_ext;
    logic [CW+bdq_pkg::COUNT_W-1:0] cnt_ext;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Ring address of the slot after the back entry.
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    assign back_addr = back_wrap[PW-1:0];

    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + PW'(1);
    assign scan_ptr_next = (scan_ptr_reg == PW'(DEPTH - 1)) ? '0 : scan_ptr_reg + PW'(1);

    assign match = cmp_valid_reg && (rd_data_reg == key_reg);

    assign sts.needs_scan = (mode == bdq_pkg::MODE_FIND) && !is_empty;
    assign sts.scan_done  = cmd.scan && cmp_valid_reg
                            && (match || (cmp_idx_reg == count_reg - CW'(1)));

    assign pos_ext = (CW + bdq_pkg::POS_W)'(cmp_idx_reg);

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        wr_addr      = back_addr;
        status_next  = status_reg;
        pos_next     = pos_reg;
        if (cmd.accept)
        begin
            status_next = bdq_pkg::ST_OK;
            pos_next    = '0;
            unique case (mode)
                bdq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdq_pkg::MODE_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                bdq_pkg::MODE_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                bdq_pkg::MODE_FIND:
                begin
                    // An empty ring answers at once; otherwise the search fills this in.
                    status_next = bdq_pkg::ST_NOT_FOUND;
                end
                bdq_pkg::MODE_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (sts.scan_done)
        begin
            if (match)
            begin
                status_next = bdq_pkg::ST_OK;
                pos_next    = pos_ext[bdq_pkg::POS_W-1:0];
            end
            else
            begin
                status_next = bdq_pkg::ST_NOT_FOUND;
                pos_next    = '0;
            end
        end
    end

    assign cnt_ext      = (CW + bdq_pkg::COUNT_W)'(count_next);
    assign cnt_out_next = cnt_ext[bdq_pkg::COUNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[scan_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.accept)
            begin
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= 1'b1;
            end
        end
    end

    // Search pointers and result word carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scan_ptr_reg  <= front_reg;
            issue_idx_reg <= '0;
            key_reg       <= value;
        end
        else if (cmd.scan)
        begin
            scan_ptr_reg  <= scan_ptr_next;
            issue_idx_reg <= issue_idx_reg + CW'(1);
            cmp_idx_reg   <= issue_idx_reg;
        end
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        if (cmd.accept)
        begin
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign status         = status_reg;
    assign found_position = pos_reg;
    assign entry_count    = cnt_out_reg;

endmodule

// ===== design/bounded_deque_with_search.sv =====
// Channel  Direction  Fields                                   Handshake
// req      in         mode[2:0], value[31:0] (signed)          valid/ready
// rsp      out        status[1:0], found_position[3:0],        valid/ready
//                     entry_count[4:0]
//
// For push, pop, clear and unused codes, and a find over an empty ring, the word is
// accepted and its response is registered at the same edge.
// A find reads the held entries through the one registered read port of the
// ring store, and the search compares one entry per cycle.
// After reset the ring is empty; the store contents themselves are not cleared.
// A waiting response blocks the next request word until it is taken; the
// word can be accepted in the same cycle that the response is taken.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    // Command and status between the sequencing control and the ring datapath.
    bdq_pkg::bdq_cmd_t cmd;
    bdq_pkg::bdq_sts_t sts;
    logic              in_ready;
    logic              out_valid;

    // The controller owns the handshakes and ends a find when the datapath reports it done.
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the ring store, the front and count registers, the
    // search pipeline and the registered response word.
    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (req.mode),
        .value          (req.value),
        .status         (rsp.status),
        .found_position (rsp.found_position),
        .entry_count    (rsp.entry_count)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam int DEPTH = bdq_pkg::DEPTH_DEFAULT;

    // The two operation codes that the block treats as no-ops.
    localparam logic [bdq_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [bdq_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Number and length of the random blocks of request words after the directed opening.
    localparam int RANDOM_BLOCKS = 62;
    localparam int BLOCK_LEN     = 32;

    // Guard against a hung handshake. The limit leaves room for a correct run
    // even with every find walking the full ring and both sides at their
    // longest idle stretches.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Length of the deliberate response hold-off, in cycles.
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic        [bdq_pkg::MODE_W-1:0]  mode;
        logic signed [bdq_pkg::VALUE_W-1:0] value;
    } request_t;

    typedef struct {
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::POS_W-1:0]    found_position;
        logic [bdq_pkg::COUNT_W-1:0]  entry_count;
    } response_t;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Request words still to be offered, and responses that the ring
    // predictor says must come back, oldest first.
    request_t  request_backlog[$];
    response_t awaited_responses[$];

    // Predictor state: a private copy of the ring, its front slot and fill.
    logic signed [bdq_pkg::VALUE_W-1:0] ring_entries [DEPTH];
    int                                 ring_head;
    int                                 ring_fill;

    // Handshake bookkeeping. offered_count moves when the driver puts a new
    // word on the bus, taken_count when the block accepts one; the two are
    // equal whenever the bus is free for the next word.
    int offered_count;
    int taken_count;
    int send_gap;
    int drain_pause;
    int cycle_count;
    int mismatches;
    logic rsp_hold;

    response_t predicted;
    response_t oldest;
    request_t  next_word;

    // In every fourth window of the cycle counter both sides run flat out, so
    // that back-to-back traffic is seen as well as the ragged kind.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if ((cycle_count / 512) % 4 == 0)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Values come mostly from a narrow band so that pushes repeat and
    // finds hit, with full-width noise and the two extremes mixed in.
    function automatic logic signed [bdq_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return $signed($urandom_range(0, 9)) - 4;
        if (roll < 90)
            return $urandom;
        if (roll < 95)
            return 32'sh7fff_ffff;
        return 32'sh8000_0000;
    endfunction

    task automatic queue_request(input logic [bdq_pkg::MODE_W-1:0] m,
                                 input logic signed [bdq_pkg::VALUE_W-1:0] v);
        request_t rq;
        rq.mode  = m;
        rq.value = v;
        request_backlog.push_back(rq);
    endtask

    // Applies one accepted request word to the predictor's ring and works
    // out the response that the block must give for it.
    task automatic deque_apply(input request_t rq, output response_t rs);
        bit hit;
        rs.status         = bdq_pkg::ST_OK;
        rs.found_position = '0;
        hit               = 1'b0;
        case (rq.mode)
            bdq_pkg::MODE_PUSH_BACK:
            begin
                if (ring_fill >= DEPTH)
                    rs.status = bdq_pkg::ST_FULL;
                else
                begin
                    ring_entries[(ring_head + ring_fill) % DEPTH] = rq.value;
                    ring_fill++;
                end
            end
            bdq_pkg::MODE_PUSH_FRONT:
            begin
                if (ring_fill >= DEPTH)
                    rs.status = bdq_pkg::ST_FULL;
                else
                begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_entries[ring_head] = rq.value;
                    ring_fill++;
                end
            end
            bdq_pkg::MODE_POP_BACK:
            begin
                if (ring_fill == 0)
                    rs.status = bdq_pkg::ST_EMPTY;
                else
                    ring_fill--;
            end
            bdq_pkg::MODE_POP_FRONT:
            begin
                if (ring_fill == 0)
                    rs.status = bdq_pkg::ST_EMPTY;
                else
                begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            bdq_pkg::MODE_FIND:
            begin
                // The first match counted from the front wins.
                for (int i = 0; i < ring_fill && !hit; i++)
                begin
                    if (ring_entries[(ring_head + i) % DEPTH] == rq.value)
                    begin
                        hit               = 1'b1;
                        rs.found_position = i[bdq_pkg::POS_W-1:0];
                    end
                end
                if (!hit)
                    rs.status = bdq_pkg::ST_NOT_FOUND;
            end
            bdq_pkg::MODE_CLEAR:
            begin
                ring_head = 0;
                ring_fill = 0;
            end
            default:
            begin
            end
        endcase
        rs.entry_count = ring_fill[bdq_pkg::COUNT_W-1:0];
    endtask

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset is applied once and released on a falling edge so that the
    // first request word can follow cleanly.
    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = bdq_pkg::MODE_PUSH_BACK;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Stimulus. The directed opening walks the empty ring, the no-op codes,
    // both extremes of the value field, a search that must return the first
    // of two equal entries, and a clear followed by another empty pop. The
    // random part then runs in blocks of 32 words, each leaning towards
    // filling, draining, mixing or searching, so that the ring reaches full
    // and empty repeatedly and its front slot wraps in both directions.
    initial
    begin
        int kind;
        int roll;
        int push_pct;
        int pop_pct;
        logic [bdq_pkg::MODE_W-1:0] m;

        queue_request(bdq_pkg::MODE_POP_BACK,   $urandom);
        queue_request(bdq_pkg::MODE_POP_FRONT,  $urandom);
        queue_request(bdq_pkg::MODE_FIND,       32'sd0);
        queue_request(MODE_SPARE_LO,            32'sd0);
        queue_request(MODE_SPARE_HI,            32'shffff_ffff);
        queue_request(bdq_pkg::MODE_PUSH_BACK,  32'sh7fff_ffff);
        queue_request(bdq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
        queue_request(bdq_pkg::MODE_PUSH_BACK,  32'sd0);
        queue_request(bdq_pkg::MODE_PUSH_FRONT, -32'sd1);
        queue_request(bdq_pkg::MODE_FIND,       -32'sd1);
        queue_request(bdq_pkg::MODE_FIND,       32'sh7fff_ffff);
        queue_request(bdq_pkg::MODE_FIND,       32'sd0);
        queue_request(bdq_pkg::MODE_FIND,       32'sd12345);
        queue_request(bdq_pkg::MODE_PUSH_BACK,  -32'sd1);
        queue_request(bdq_pkg::MODE_FIND,       -32'sd1);
        queue_request(bdq_pkg::MODE_POP_FRONT,  $urandom);
        queue_request(bdq_pkg::MODE_FIND,       -32'sd1);
        queue_request(bdq_pkg::MODE_POP_BACK,   $urandom);
        queue_request(bdq_pkg::MODE_FIND,       -32'sd1);
        queue_request(bdq_pkg::MODE_CLEAR,      $urandom);
        queue_request(bdq_pkg::MODE_POP_BACK,   $urandom);
        queue_request(bdq_pkg::MODE_FIND,       32'sh8000_0000);
        queue_request(bdq_pkg::MODE_PUSH_FRONT, 32'sd7);

        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0:       begin push_pct = 70; pop_pct = 10; end
                1:       begin push_pct = 10; pop_pct = 70; end
                2:       begin push_pct = 35; pop_pct = 35; end
                default: begin push_pct = 20; pop_pct = 18; end
            endcase
            for (int k = 0; k < BLOCK_LEN; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    m = $urandom_range(0, 1) ? bdq_pkg::MODE_PUSH_FRONT
                                             : bdq_pkg::MODE_PUSH_BACK;
                else if (roll < push_pct + pop_pct)
                    m = $urandom_range(0, 1) ? bdq_pkg::MODE_POP_FRONT
                                             : bdq_pkg::MODE_POP_BACK;
                else if (roll < 98)
                    m = bdq_pkg::MODE_FIND;
                else if (roll == 98)
                    m = bdq_pkg::MODE_CLEAR;
                else
                    m = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                queue_request(m, pick_value());
            end
        end
    end

    // Request driver. A new word goes out on the falling edge once the
    // previous one has been taken and any idle gap has run down; a word
    // that has not yet been taken is simply held.
    always @(negedge clk)
    begin
        if (rst_n && taken_count == offered_count)
        begin
            if (send_gap > 0 || request_backlog.size() == 0)
            begin
                req_ch.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                next_word = request_backlog.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.mode   <= next_word.mode;
                req_ch.value  <= next_word.value;
                offered_count <= offered_count + 1;
                send_gap      <= idle_length();
            end
        end
    end

    // Response side back-pressure. Ready drops for random stretches, and
    // for the whole of the deliberate hold-off below.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_hold || drain_pause > 0)
            begin
                rsp_ch.ready <= 1'b0;
                if (!rsp_hold)
                    drain_pause <= drain_pause - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                drain_pause  <= idle_length();
            end
        end
    end

    // Once the traffic is well under way the receiver stops taking
    // responses for a long stretch while the driver keeps offering words,
    // so the block has to hold its result and stall the request channel.
    initial
    begin
        rsp_hold = 1'b0;
        wait (taken_count >= 300);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Monitor and scoreboard, both on the rising edge. A response is
    // checked before the word accepted at the same edge is predicted; that
    // word's response can only appear at a later edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_head   = 0;
            ring_fill   = 0;
            taken_count <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d",
                           rsp_ch.status);
                    mismatches++;
                end
                else
                begin
                    oldest = awaited_responses.pop_front();
                    if (rsp_ch.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               oldest.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.found_position !== oldest.found_position)
                    begin
                        $error("found_position: expected %0d, got %0d",
                               oldest.found_position, rsp_ch.found_position);
                        mismatches++;
                    end
                    if (rsp_ch.entry_count !== oldest.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               oldest.entry_count, rsp_ch.entry_count);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                next_word.mode  = req_ch.mode;
                next_word.value = req_ch.value;
                deque_apply(next_word, predicted);
                awaited_responses.push_back(predicted);
                taken_count <= taken_count + 1;
            end
        end
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Bookkeeping starts from a known state whether or not the monitor
    // sees the opening reset edge.
    initial
    begin
        offered_count = 0;
        taken_count   = 0;
        ring_head     = 0;
        ring_fill     = 0;
        send_gap      = 0;
        drain_pause   = 0;
        cycle_count   = 0;
        mismatches    = 0;
    end

    // End of run: every word accepted, every response back, then a short
    // quiet period in which any stray response would still be caught.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (request_backlog.size() != 0 || taken_count != offered_count)
            @(posedge clk);
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (4 * DEPTH) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bdq_pkg.sv
design/bdq_req_if.sv
design/bdq_rsp_if.sv
design/bdq_ctrl.sv
design/bdq_datapath.sv
design/bounded_deque_with_search.sv
dv/tb.sv
